### hdl/six_channel_moving_average_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef SIX_CHANNEL_MOVING_AVERAGE_MACROS_SVH
`define SIX_CHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define SCMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scma assertion failed");

// Next-cycle implication, checked on the rising edge outside reset.
`define SCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scma assertion failed");

`endif

### hdl/scma_pkg.sv
`timescale 1ns / 1ps

package scma_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int CHANNELS   = 6;
    localparam int SAMPLE_W   = 16;
    // Running sum holds WINDOW_LEN full-scale samples plus a sign bit.
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
    localparam int MAG_W      = SUM_W - 1;

    // Divide by WINDOW_LEN as multiply by a rounded-up reciprocal and shift.
    // Exact for every magnitude below 2**MAG_W.
    localparam int RECIP_SHIFT = MAG_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W     = MAG_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int PROD_W = MAG_W + RECIP_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [MAG_W-1:0]           t_mag;
    typedef logic [PROD_W-1:0]          t_prod;
    typedef logic [SAMPLE_W-1:0]        t_quo;

    typedef struct packed {
        logic load_prod;
        logic load_avg;
    } t_div_ctl;

endpackage

### hdl/scma_in_if.sv
`timescale 1ns / 1ps

interface scma_in_if;
    logic              valid;
    logic              ready;
    scma_pkg::t_sample accel_x;
    scma_pkg::t_sample accel_y;
    scma_pkg::t_sample accel_z;
    scma_pkg::t_sample rate_x;
    scma_pkg::t_sample rate_y;
    scma_pkg::t_sample rate_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
        output ready
    );
endinterface

### hdl/scma_out_if.sv
`timescale 1ns / 1ps

interface scma_out_if;
    logic              valid;
    logic              ready;
    scma_pkg::t_sample avg_accel_x;
    scma_pkg::t_sample avg_accel_y;
    scma_pkg::t_sample avg_accel_z;
    scma_pkg::t_sample avg_rate_x;
    scma_pkg::t_sample avg_rate_y;
    scma_pkg::t_sample avg_rate_z;

    modport source (
        output valid, avg_accel_x, avg_accel_y, avg_accel_z,
               avg_rate_x, avg_rate_y, avg_rate_z,
        input  ready
    );
    modport sink (
        input  valid, avg_accel_x, avg_accel_y, avg_accel_z,
               avg_rate_x, avg_rate_y, avg_rate_z,
        output ready
    );
endinterface

### hdl/six_channel_moving_average.sv
`timescale 1ns / 1ps
// Six-channel moving average over the last ten samples of each axis.
// Input channel i_sample carries one six-axis sample per transaction:
// accel_x/y/z and rate_x/y/z, signed 16 bit. Output channel o_avg carries
// one transaction per input transaction with the six window averages,
// each the window sum divided by ten and truncated toward zero.
// Both channels use valid/ready; a transaction moves when both are high.
// Pipeline: an accepted sample passes through three registers in order,
// running sum, reciprocal product and result, before it shows on o_avg.
// Throughput: one sample per cycle while the receiver takes results;
// the divide is a constant reciprocal multiply split over two stages.
// Reset (synchronous, active low) clears every window and running sum to
// zero and empties the pipeline, so the first nine results average in
// zeros. When the receiver stalls, results hold in the output register
// and the pipeline fills; i_sample.ready drops only once all three stages
// hold results, and rises again in the cycle the receiver takes one.
`include "six_channel_moving_average_macros.svh"

module six_channel_moving_average (
    input  logic            i_clk,
    input  logic            i_rst_n,
    scma_in_if.sink         i_sample,
    scma_out_if.source      o_avg
);

    // Pipeline occupancy, one flag per stage.
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic w_adv3, w_adv2, w_ready, w_accept;
    scma_pkg::t_div_ctl w_ctl;

    scma_pkg::t_sample w_sample [scma_pkg::CHANNELS];
    scma_pkg::t_sum    w_sum    [scma_pkg::CHANNELS];
    scma_pkg::t_sample w_avg    [scma_pkg::CHANNELS];

    // Advance a stage whenever the stage after it is empty or draining.
    always_comb begin
        w_adv3   = !r_v3 || o_avg.ready;
        w_adv2   = !r_v2 || w_adv3;
        w_ready  = !r_v1 || w_adv2;
        w_accept = i_sample.valid && w_ready;
        n_v1     = w_ready ? w_accept : r_v1;
        n_v2     = w_adv2  ? r_v1     : r_v2;
        n_v3     = w_adv3  ? r_v2     : r_v3;
        w_ctl.load_prod = w_adv2;
        w_ctl.load_avg  = w_adv3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign i_sample.ready = w_ready;
    assign o_avg.valid    = r_v3;

    // Gather the six axes so each lane is identical.
    assign w_sample[0] = i_sample.accel_x;
    assign w_sample[1] = i_sample.accel_y;
    assign w_sample[2] = i_sample.accel_z;
    assign w_sample[3] = i_sample.rate_x;
    assign w_sample[4] = i_sample.rate_y;
    assign w_sample[5] = i_sample.rate_z;

    // Per-axis lane: window and running sum, then the divider.
    for (genvar c = 0; c < scma_pkg::CHANNELS; c++) begin : g_lane
        scma_window u_window (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_accept),
            .i_sample (w_sample[c]),
            .o_sum    (w_sum[c])
        );

        scma_divide u_divide (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_sum (w_sum[c]),
            .o_avg (w_avg[c])
        );
    end

    assign o_avg.avg_accel_x = w_avg[0];
    assign o_avg.avg_accel_y = w_avg[1];
    assign o_avg.avg_accel_z = w_avg[2];
    assign o_avg.avg_rate_x  = w_avg[3];
    assign o_avg.avg_rate_y  = w_avg[4];
    assign o_avg.avg_rate_z  = w_avg[5];

    // Full pipeline with a stalled receiver must refuse new samples.
    `SCMA_ASSERT_NOW(a_full_blocks, i_clk, i_rst_n, r_v1 && r_v2 && r_v3 && !o_avg.ready, !w_ready)
    // An accepted sample always occupies the sum stage next cycle.
    `SCMA_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_v1)
    // A product moving on reaches the output register.
    `SCMA_ASSERT_NEXT(a_prod_moves, i_clk, i_rst_n, r_v2 && w_adv3, r_v3)
    // A held sum stage must not lose its item.
    `SCMA_ASSERT_NEXT(a_sum_holds, i_clk, i_rst_n, r_v1 && !w_adv2, r_v1 && $stable(w_sum[0]))

endmodule

### hdl/scma_window.sv
`timescale 1ns / 1ps

// One channel: sample shift line and its running sum.
module scma_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  scma_pkg::t_sample i_sample,
    output scma_pkg::t_sum    o_sum
);

    scma_pkg::t_sample r_taps [scma_pkg::WINDOW_LEN];
    scma_pkg::t_sum    r_sum;
    scma_pkg::t_sum    n_sum;

    // Add the newest sample, drop the oldest one leaving the line.
    always_comb begin
        n_sum = r_sum + scma_pkg::t_sum'(i_sample)
                      - scma_pkg::t_sum'(r_taps[scma_pkg::WINDOW_LEN-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < scma_pkg::WINDOW_LEN; k++) begin
                r_taps[k] <= '0;
            end
            r_sum <= '0;
        end else if (i_shift) begin
            r_taps[0] <= i_sample;
            for (int k = 1; k < scma_pkg::WINDOW_LEN; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### hdl/scma_divide.sv
`timescale 1ns / 1ps

// Signed divide by the window length, truncating toward zero.
// Stage one: magnitude times reciprocal. Stage two: shift and restore sign.
module scma_divide (
    input  logic               i_clk,
    input  scma_pkg::t_div_ctl i_ctl,
    input  scma_pkg::t_sum     i_sum,
    output scma_pkg::t_sample  o_avg
);

    scma_pkg::t_sum    w_abs;
    scma_pkg::t_mag    w_mag;
    scma_pkg::t_prod   n_prod;
    scma_pkg::t_prod   r_prod;
    logic              r_neg;
    scma_pkg::t_quo    w_quo;
    scma_pkg::t_sample n_avg;
    scma_pkg::t_sample r_avg;

    always_comb begin
        w_abs  = i_sum[scma_pkg::SUM_W-1] ? -i_sum : i_sum;
        w_mag  = w_abs[scma_pkg::MAG_W-1:0];
        n_prod = {{(scma_pkg::PROD_W-scma_pkg::MAG_W){1'b0}}, w_mag} * scma_pkg::RECIP;
    end

    always_comb begin
        w_quo = r_prod[scma_pkg::RECIP_SHIFT +: scma_pkg::SAMPLE_W];
        n_avg = r_neg ? scma_pkg::t_sample'(-w_quo) : scma_pkg::t_sample'(w_quo);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= n_prod;
            r_neg  <= i_sum[scma_pkg::SUM_W-1];
        end
        if (i_ctl.load_avg) begin
            r_avg <= n_avg;
        end
    end

    assign o_avg = r_avg;

endmodule
